// ----- design/rab_pkg.sv -----
// ----------------------------------------------------------------------------
// rab_pkg
// shared widths, constants and beat layouts for the row activity bounds unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rab_pkg;

    localparam int unsigned VAL_W   = 32;   // q16.16 operand width
    localparam int unsigned SUM_W   = 64;   // q32.32 accumulator width
    localparam int unsigned CNT_W   = 11;   // infinity counter width
    localparam int unsigned S_DATA_W = 96;
    localparam int unsigned S_USER_W = 2;
    localparam int unsigned M_DATA_W = 152;
    localparam int unsigned M_USER_W = 3;

    localparam logic [CNT_W-1:0] CNT_TOP = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_POS_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_NEG_MAX = {1'b1, {(SUM_W-1){1'b0}}};

    // one nonzero after the input register
    typedef struct packed {
        logic                    last;
        logic                    upper_inf;
        logic                    lower_inf;
        logic signed [VAL_W-1:0] upper;
        logic signed [VAL_W-1:0] lower;
        logic signed [VAL_W-1:0] coeff;
    } t_elem;

    // selected terms after the product register
    typedef struct packed {
        logic                    last;
        logic                    min_inf;
        logic                    max_inf;
        logic signed [SUM_W-1:0] min_term;
        logic signed [SUM_W-1:0] max_term;
    } t_terms;

endpackage

`default_nettype wire

// ----- design/row_activity_bounds_unit.sv -----
// ----------------------------------------------------------------------------
// row_activity_bounds_unit
// minimum and maximum activity of one lp constraint row, streamed per nonzero
// ----------------------------------------------------------------------------
// usage:
//   slave channel: one beat per row nonzero, carrying the coefficient and the
//   column bounds (q16.16) in tdata, the two bound infinity flags in tuser and
//   tlast on the final nonzero of the row
//   master channel: one beat per row, sent after the tlast beat, carrying both
//   q32.32 activity sums, both infinity counts, the finite flags and a
//   saturation flag
//   result path: a row's tlast beat passes the input register and the product
//   register, then the accumulator writes the row's result to the result reg
//   throughput: one nonzero per cycle when not stalled, set by the two 32x32
//   multipliers and the 64-bit saturating accumulators, each one term per cycle
//   reset: sums, counts, flags and all valid bits clear; no row in flight
//   stall: while a result waits, nonzeros of the next row keep flowing and
//   accumulating; only a second tlast beat reaching the accumulator holds
//   the pipeline until the waiting result is taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module row_activity_bounds_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // slave side
    input  wire logic                          i_s_axis_tvalid,
    output      logic                          o_s_axis_tready,
    // coefficient[31:0], lower_bound[63:32], upper_bound[95:64]
    input  wire logic [rab_pkg::S_DATA_W-1:0]  i_s_axis_tdata,
    // lower_is_infinite[0], upper_is_infinite[1]
    input  wire logic [rab_pkg::S_USER_W-1:0]  i_s_axis_tuser,
    input  wire logic                          i_s_axis_tlast,
    // master side
    output      logic                          o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // min_activity[63:0], max_activity[127:64], min_infinite_count[138:128],
    // max_infinite_count[149:139], zero pad[151:150]
    output      logic [rab_pkg::M_DATA_W-1:0]  o_m_axis_tdata,
    // min_is_finite[0], max_is_finite[1], saturated[2]
    output      logic [rab_pkg::M_USER_W-1:0]  o_m_axis_tuser
);

    localparam int unsigned SW = rab_pkg::SUM_W;
    localparam int unsigned CW = rab_pkg::CNT_W;

    // pipeline control
    logic r_in_valid, n_in_valid;
    logic r_p_valid,  n_p_valid;
    logic r_out_valid, n_out_valid;
    logic acc_stall, p_move, p_free, in_move, in_free, s_take, out_load;

    // stage registers
    rab_pkg::t_elem  r_in, n_in;
    rab_pkg::t_terms r_p, n_p;

    // row state
    logic [SW-1:0] r_min_sum, n_min_sum;
    logic [SW-1:0] r_max_sum, n_max_sum;
    logic [CW-1:0] r_min_cnt, n_min_cnt;
    logic [CW-1:0] r_max_cnt, n_max_cnt;
    logic          r_ovf, n_ovf;

    // result register
    logic [SW-1:0] r_o_min, n_o_min;
    logic [SW-1:0] r_o_max, n_o_max;
    logic [CW-1:0] r_o_min_cnt, n_o_min_cnt;
    logic [CW-1:0] r_o_max_cnt, n_o_max_cnt;
    logic          r_o_sat, n_o_sat;

    // accumulate datapath
    logic [SW-1:0] min_add, max_add, min_acc, max_acc;
    logic [CW-1:0] min_cnt_acc, max_cnt_acc;
    logic          min_ovf, max_ovf;

    // product datapath
    logic                           coeff_pos;
    logic signed [rab_pkg::VAL_W-1:0] b_min, b_max;
    logic signed [SW-1:0]           prod_min, prod_max;

    // handshake: a tlast term only stalls when the result slot stays full
    always_comb begin
        acc_stall = r_p_valid & r_p.last & r_out_valid & ~i_m_axis_tready;
        p_move    = r_p_valid & ~acc_stall;
        p_free    = ~r_p_valid | p_move;
        in_move   = r_in_valid & p_free;
        in_free   = ~r_in_valid | in_move;
        s_take    = i_s_axis_tvalid & in_free;
        out_load  = p_move & r_p.last;
    end

    assign o_s_axis_tready = in_free;

    // unpack the incoming beat
    always_comb begin
        n_in_valid = s_take | (r_in_valid & ~in_move);
        if (s_take) begin
            n_in.coeff     = i_s_axis_tdata[31:0];
            n_in.lower     = i_s_axis_tdata[63:32];
            n_in.upper     = i_s_axis_tdata[95:64];
            n_in.lower_inf = i_s_axis_tuser[0];
            n_in.upper_inf = i_s_axis_tuser[1];
            n_in.last      = i_s_axis_tlast;
        end else begin
            n_in = r_in;
        end
    end

    // bound selection by coefficient sign, zero coefficient takes the swapped
    // pair like a negative one
    always_comb begin
        coeff_pos = ~r_in.coeff[rab_pkg::VAL_W-1] & (|r_in.coeff);
        b_min     = coeff_pos ? r_in.lower : r_in.upper;
        b_max     = coeff_pos ? r_in.upper : r_in.lower;
        prod_min  = r_in.coeff * b_min;
        prod_max  = r_in.coeff * b_max;
    end

    always_comb begin
        n_p_valid = in_move | (r_p_valid & ~p_move);
        if (in_move) begin
            n_p.min_term = prod_min;
            n_p.max_term = prod_max;
            n_p.min_inf  = coeff_pos ? r_in.lower_inf : r_in.upper_inf;
            n_p.max_inf  = coeff_pos ? r_in.upper_inf : r_in.lower_inf;
            n_p.last     = r_in.last;
        end else begin
            n_p = r_p;
        end
    end

    // saturating accumulation, infinite terms go to the counters instead
    always_comb begin
        min_add = r_min_sum + r_p.min_term;
        max_add = r_max_sum + r_p.max_term;
        min_ovf = ~r_p.min_inf & (r_min_sum[SW-1] == r_p.min_term[SW-1])
                  & (min_add[SW-1] != r_min_sum[SW-1]);
        max_ovf = ~r_p.max_inf & (r_max_sum[SW-1] == r_p.max_term[SW-1])
                  & (max_add[SW-1] != r_max_sum[SW-1]);

        if (r_p.min_inf) begin
            min_acc = r_min_sum;
        end else if (min_ovf) begin
            min_acc = r_min_sum[SW-1] ? rab_pkg::SUM_NEG_MAX : rab_pkg::SUM_POS_MAX;
        end else begin
            min_acc = min_add;
        end

        if (r_p.max_inf) begin
            max_acc = r_max_sum;
        end else if (max_ovf) begin
            max_acc = r_max_sum[SW-1] ? rab_pkg::SUM_NEG_MAX : rab_pkg::SUM_POS_MAX;
        end else begin
            max_acc = max_add;
        end

        // counters stop at the top of their range
        min_cnt_acc = (r_p.min_inf && r_min_cnt != rab_pkg::CNT_TOP)
                      ? r_min_cnt + CW'(1) : r_min_cnt;
        max_cnt_acc = (r_p.max_inf && r_max_cnt != rab_pkg::CNT_TOP)
                      ? r_max_cnt + CW'(1) : r_max_cnt;
    end

    // row state update, cleared after the tlast term
    always_comb begin
        n_min_sum = r_min_sum;
        n_max_sum = r_max_sum;
        n_min_cnt = r_min_cnt;
        n_max_cnt = r_max_cnt;
        n_ovf     = r_ovf;
        if (p_move) begin
            if (r_p.last) begin
                n_min_sum = '0;
                n_max_sum = '0;
                n_min_cnt = '0;
                n_max_cnt = '0;
                n_ovf     = 1'b0;
            end else begin
                n_min_sum = min_acc;
                n_max_sum = max_acc;
                n_min_cnt = min_cnt_acc;
                n_max_cnt = max_cnt_acc;
                n_ovf     = r_ovf | min_ovf | max_ovf;
            end
        end
    end

    // result slot
    always_comb begin
        n_out_valid = out_load | (r_out_valid & ~i_m_axis_tready);
        if (out_load) begin
            n_o_min     = min_acc;
            n_o_max     = max_acc;
            n_o_min_cnt = min_cnt_acc;
            n_o_max_cnt = max_cnt_acc;
            n_o_sat     = r_ovf | min_ovf | max_ovf;
        end else begin
            n_o_min     = r_o_min;
            n_o_max     = r_o_max;
            n_o_min_cnt = r_o_min_cnt;
            n_o_max_cnt = r_o_max_cnt;
            n_o_sat     = r_o_sat;
        end
    end

    // control and row state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_min_sum   <= '0;
            r_max_sum   <= '0;
            r_min_cnt   <= '0;
            r_max_cnt   <= '0;
            r_ovf       <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_p_valid   <= n_p_valid;
            r_out_valid <= n_out_valid;
            r_min_sum   <= n_min_sum;
            r_max_sum   <= n_max_sum;
            r_min_cnt   <= n_min_cnt;
            r_max_cnt   <= n_max_cnt;
            r_ovf       <= n_ovf;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_in        <= n_in;
        r_p         <= n_p;
        r_o_min     <= n_o_min;
        r_o_max     <= n_o_max;
        r_o_min_cnt <= n_o_min_cnt;
        r_o_max_cnt <= n_o_max_cnt;
        r_o_sat     <= n_o_sat;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_o_max_cnt, r_o_min_cnt, r_o_max, r_o_min};
    assign o_m_axis_tuser  = {r_o_sat, (r_o_max_cnt == '0), (r_o_min_cnt == '0)};

endmodule

`default_nettype wire
